FILE: rtl/itda_pkg.sv
// Shared types, constants and widths for the integer to decimal ASCII converter.
package itda_pkg;

  // Field widths of the two channels.
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;

  // Decimal layout: 20 BCD digits cover every 64-bit magnitude.
  localparam int DIGITS  = 20;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int IDX_W   = $clog2(DIGITS);

  // Double-dabble: bits taken from the magnitude in each cycle, and steps per item.
  localparam int STEP_BITS = 4;
  localparam int STEPS     = VALUE_W / STEP_BITS;
  localparam int STEP_W    = $clog2(STEPS);

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // One input beat.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               as_signed;
  } itda_in_t;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } itda_out_t;

  // Classified work item: sign flag and unsigned magnitude.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } itda_work_t;

  // Converted number: sign flag and all decimal digits, least significant digit lowest.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } itda_bcd_t;

endpackage

FILE: rtl/itda_front.sv
// Front stage: accepts input beats and splits each value into sign and magnitude.
module itda_front
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  itda_in_t   in_data,
  output logic       q_push,
  output itda_work_t q_data,
  input  logic       q_full
);

  logic       valid_r;
  logic       valid_nxt;
  itda_work_t work_r;
  itda_work_t work_nxt;
  logic       accept;
  logic       neg;

  // The stage is full only while its item cannot move into the queue.
  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_data = work_r;

  // A negative signed value is negated; the most negative one comes out as 2^63.
  always_comb begin
    neg               = in_data.as_signed && in_data.value[VALUE_W-1];
    work_nxt.neg      = neg;
    work_nxt.mag      = neg ? (~in_data.value + VALUE_W'(1)) : in_data.value;
    valid_nxt         = (valid_r && q_full) || accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r <= work_nxt;
    end
  end

endmodule

FILE: rtl/itda_queue.sv
// Short first-in first-out queue of classified items between the front and the back.
module itda_queue
  import itda_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  itda_work_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output itda_work_t data_o,
  output logic       empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itda_work_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  // Pointers wrap at the depth, so any depth works.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

FILE: rtl/itda_conv.sv
// Back conversion unit: double-dabble of the magnitude into BCD, several bits per cycle.
module itda_conv
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  itda_work_t q_data,
  output logic       q_pop,
  output logic       res_valid,
  output itda_bcd_t  res_data,
  input  logic       res_ready
);

  logic               busy_r;
  logic               busy_nxt;
  logic               done_r;
  logic               done_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [STEP_W-1:0]  step_nxt;
  logic               neg_r;
  logic [VALUE_W-1:0] sh_r;
  logic [VALUE_W-1:0] sh_nxt;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_nxt;
  logic               start;
  logic               take;

  assign take      = done_r && res_ready;
  assign start     = !busy_r && (!done_r || take) && !q_empty;
  assign q_pop     = start;
  assign res_valid = done_r;
  assign res_data  = '{neg: neg_r, bcd: bcd_r};

  // Shift STEP_BITS magnitude bits into the digits, adding three to every digit of five or more.
  always_comb begin
    logic [BCD_W-1:0]   bcd_v;
    logic [VALUE_W-1:0] sh_v;
    bcd_v = bcd_r;
    sh_v  = sh_r;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_v[4*d +: 4] >= 4'd5) begin
          bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
        end
      end
      bcd_v = {bcd_v[BCD_W-2:0], sh_v[VALUE_W-1]};
      sh_v  = {sh_v[VALUE_W-2:0], 1'b0};
    end
    bcd_nxt = bcd_v;
    sh_nxt  = sh_v;
  end

  // Sequencing: idle, run through the STEPS steps, then hold the result until the emitter takes it.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    if (take) begin
      done_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers: loaded at start, advanced while running.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= q_data.neg;
      sh_r  <= q_data.mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      bcd_r <= bcd_nxt;
    end
  end

endmodule

FILE: rtl/itda_emit.sv
// Back emitter: turns a BCD number into characters, most significant first, into the output register.
module itda_emit
  import itda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  itda_bcd_t res_data,
  output logic      res_ready,
  output logic      empty,
  input  logic      pop,
  output itda_out_t out_data
);

  logic              busy_r;
  logic              busy_nxt;
  logic              sign_r;
  logic              sign_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [BCD_W-1:0]  bcd_r;
  logic              valid_r;
  logic              valid_nxt;
  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;
  logic              last_r;
  logic              last_nxt;
  logic [IDX_W-1:0]  top_idx;
  logic              load;
  logic              adv;

  assign res_ready = !busy_r;
  assign load      = res_valid && !busy_r;
  assign adv       = busy_r && (!valid_r || pop);
  assign empty     = !valid_r;
  assign out_data  = '{char_code: char_r, last_char: last_r};

  // Highest nonzero digit; zero still gives one digit at position zero.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (res_data.bcd[4*d +: 4] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  // Next character: the sign first when pending, then digits down to position zero.
  always_comb begin
    busy_nxt  = busy_r;
    sign_nxt  = sign_r;
    idx_nxt   = idx_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !pop;
    if (load) begin
      busy_nxt = 1'b1;
      sign_nxt = res_data.neg;
      idx_nxt  = top_idx;
    end else if (adv) begin
      valid_nxt = 1'b1;
      if (sign_r) begin
        char_nxt = CHAR_MINUS;
        last_nxt = 1'b0;
        sign_nxt = 1'b0;
      end else begin
        char_nxt = CHAR_ZERO + {4'd0, bcd_r[4*idx_r +: 4]};
        last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      sign_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      sign_r  <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (load) begin
      bcd_r <= res_data.bcd;
    end
  end

  // Every character shown is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (char_r == CHAR_MINUS) || ((char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE)))
    else $error("emitter shows a character that is neither sign nor digit");

  // The sign never ends a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (char_r == CHAR_MINUS)) |-> !last_r)
    else $error("minus sign marked as last character");

  // The emitter frees up only as it loads a number's last character.
  a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (valid_r && last_r))
    else $error("emitter released without a last character");

endmodule

FILE: rtl/integer_to_decimal_ascii.sv
// Top level of the 64-bit integer to decimal ASCII text converter.
//
// Input channel: present in_data (value, as_signed) with push; a beat is taken at a rising
// edge with push high and full low. A signed negative value yields a leading '-'.
// Result channel: while empty is low, out_data holds the oldest character (char_code) and
// last_char, which marks the final character of a number; pop takes it. Text is most
// significant digit first, without leading zeros; zero gives a single '0'.
// Path: the front stage register, the queue, double-dabble conversion (4 magnitude bits per
// cycle), the hand-off of the digits to the emitter, and then one character per cycle into
// the output register while that register is empty or being popped.
// Overlap: the converter works on the next number while the emitter still outputs the
// previous one.
// Reset (synchronous, rst_n low) empties the front stage, queue, converter and output
// register. When the receiver holds off pop, the output register keeps its character, the
// emitter and converter stall, the queue fills and then full rises toward the sender.
module integer_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  itda_in_t  in_data,
  output logic      empty,
  input  logic      pop,
  output itda_out_t out_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  itda_work_t q_wdata;
  itda_work_t q_rdata;
  logic       res_valid;
  logic       res_ready;
  itda_bcd_t  res_data;

  itda_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  itda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  itda_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  itda_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

FILE: test/itda_checker.sv
// Checker that predicts and compares the character beats of the decimal text converter.
module itda_checker
  import itda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  itda_in_t  in_data,
  input  logic      empty,
  input  logic      pop,
  input  itda_out_t out_data,
  output int        fail_count,
  output int        chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Characters still owed by the block, oldest first.
  itda_out_t due_chars[$];

  // Spell one number in decimal and queue its characters.
  function automatic void spell_decimal(input itda_in_t number);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digit_rev[DIGITS];
    int                 n;
    itda_out_t          ch;
    neg = number.as_signed & number.value[VALUE_W-1];
    // The magnitude is taken in unsigned arithmetic, so the most negative value is safe.
    mag = neg ? (~number.value + 1'b1) : number.value;
    n   = 0;
    // Digits come out least significant first; zero still yields one digit.
    do begin
      digit_rev[n] = CHAR_ZERO + CHAR_W'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < DIGITS);
    if (neg) begin
      ch.char_code = CHAR_MINUS;
      ch.last_char = 1'b0;
      due_chars.push_back(ch);
    end
    for (int k = n - 1; k >= 0; k--) begin
      ch.char_code = digit_rev[k];
      ch.last_char = (k == 0);
      due_chars.push_back(ch);
    end
  endfunction

  // Watch both channels at every rising edge.
  always @(posedge clk) begin : watch
    itda_out_t want;
    if (rst_n) begin
      // A result beat is compared with the oldest character owed.
      if (pop && !empty) begin
        if (due_chars.size() == 0) begin
          $error("unexpected beat: char_code %h last_char %b",
                 out_data.char_code, out_data.last_char);
          fail_count++;
        end else begin
          want = due_chars.pop_front();
          if (out_data.char_code !== want.char_code) begin
            $error("char_code: expected %h, actual %h", want.char_code, out_data.char_code);
            fail_count++;
          end
          if (out_data.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char, out_data.last_char);
            fail_count++;
          end
        end
      end
      // An accepted input beat adds its text to the owed characters.
      if (push && !full) begin
        spell_decimal(in_data);
      end
    end
    chars_pending <= due_chars.size();
  end

endmodule

FILE: test/tb_integer_to_decimal_ascii.sv
// Testbench top for the integer to decimal ASCII converter: stimulus, handshakes and verdict.
module tb_integer_to_decimal_ascii;
  import itda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  itda_in_t  in_data;
  logic      empty;
  logic      pop;
  itda_out_t out_data;

  int fail_count;
  int chars_pending;
  int send_idle_pct;
  int pop_idle_pct;
  int stall_cycles;

  integer_to_decimal_ascii dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  itda_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data      (in_data),
    .empty        (empty),
    .pop          (pop),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver takes a beat or holds off at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Watchdog: too long without any accepted beat ends the run.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VALUE_W-1:0] pow10(input int d);
    logic [VALUE_W-1:0] p;
    p = VALUE_W'(1);
    for (int i = 0; i < d; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Present one number and wait until the block takes the beat.
  task automatic offer_number(input logic [VALUE_W-1:0] value, input logic as_signed);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push              <= 1'b1;
    in_data.value     <= value;
    in_data.as_signed <= as_signed;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed character has come out.
  task automatic wait_text_done();
    push <= 1'b0;
    do begin
      @(posedge clk);
    end while (chars_pending != 0);
  endtask

  // Random numbers shaped to cover every text length, the sign and the edges.
  task automatic offer_random(input int count);
    logic [VALUE_W-1:0] v;
    logic               s;
    int                 pick;
    int                 d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      s    = 1'($urandom_range(1));
      if (pick < 30) begin
        v = rand64();
      end else if (pick < 70) begin
        d = $urandom_range(1, 19);
        v = rand64() % pow10(d);
        if (s && $urandom_range(1)) begin
          v = -v;
        end
      end else if (pick < 85) begin
        // Just around a power of ten, where the digit count changes.
        d = $urandom_range(0, 19);
        v = pow10(d) + $urandom_range(2) - 1;
        if (s && $urandom_range(1)) begin
          v = -v;
        end
      end else if (pick < 93) begin
        v = VALUE_W'($urandom_range(20));
        if (s && $urandom_range(1)) begin
          v = -v;
        end
      end else begin
        // Near the signed and unsigned wrap points.
        v = $urandom_range(1) ? ({1'b1, {(VALUE_W-1){1'b0}}} + $urandom_range(3) - 2)
                              : ({VALUE_W{1'b1}} - $urandom_range(3));
      end
      offer_number(v, s);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    in_data       = '0;
    send_idle_pct = 24;
    pop_idle_pct  = 77;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, single digits, digit-count edges, signed extremes, bit patterns.
    offer_number(64'd0, 1'b0);
    offer_number(64'd0, 1'b1);
    offer_number(64'd1, 1'b0);
    offer_number(64'd9, 1'b0);
    offer_number(64'd10, 1'b0);
    offer_number(64'd99, 1'b1);
    offer_number(64'd100, 1'b0);
    offer_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    offer_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    offer_number(64'h8000_0000_0000_0000, 1'b1);
    offer_number(64'h8000_0000_0000_0000, 1'b0);
    offer_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    offer_number(64'd10000000000000000000, 1'b0);
    offer_number(64'd9999999999999999999, 1'b0);
    offer_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
    offer_number(64'hFFFF_FFFF_FFFF_FFF7, 1'b1);
    offer_number(64'd1234567890, 1'b1);
    offer_number(64'd1000000000000000000, 1'b1);
    offer_number(-64'd1000000000000000000, 1'b1);
    offer_number(64'h5555_5555_5555_5555, 1'b1);
    offer_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    offer_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Let the block run dry once before the random part.
    wait_text_done();

    offer_random(90);
    wait_text_done();

    // Swap which side idles.
    send_idle_pct = 77;
    pop_idle_pct  = 24;
    offer_random(90);
    wait_text_done();

    // Full rate on both sides.
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    offer_random(80);
    wait_text_done();

    // Give any stray beat time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
